// ===== rtl/tkss_pkg.sv =====
// Shared types and constants of the top-k score selector.
`default_nettype none

package tkss_pkg;

  // Payload field widths
  localparam int DOC_W       = 31;
  localparam int SCORE_W     = 32;
  localparam int AGE_W       = 4;
  localparam int RANK_W      = 4;
  localparam int K_W         = 5;

  // Stream word widths (whole bytes)
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  // Slot count defaults and the ranked-output cap
  localparam int MAX_SLOTS_DEF = 16;
  localparam int RESULT_CAP    = 16;
  localparam int K_RESET       = 10;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_OFFER  = 1'b0,
    OP_FINISH = 1'b1
  } tkss_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFER_SCAN,
    ST_OFFER_DONE,
    ST_FIN_SCAN,
    ST_FIN_EMIT,
    ST_FIN_EMPTY
  } tkss_state_e;

  // Classified command handed from front to back
  typedef struct packed {
    tkss_op_e           op;
    logic [DOC_W-1:0]   doc;
    logic [SCORE_W-1:0] score;
  } tkss_cmd_t;

  // One result word
  typedef struct packed {
    logic               accepted;
    logic [SCORE_W-1:0] threshold;
    logic               threshold_valid;
    logic [RANK_W-1:0]  rank;
    logic [DOC_W-1:0]   out_doc;
    logic [SCORE_W-1:0] out_score;
    logic               entry_empty;
    logic               last;
  } tkss_result_t;

endpackage

`default_nettype wire

// ===== rtl/tkss_front.sv =====
// Front part: accepts input words, classifies them and queues commands.
`default_nettype none

module tkss_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [tkss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire                                s_axis_tuser,
  output logic                               q_valid_o,
  output tkss_pkg::tkss_cmd_t                q_cmd_o,
  input  wire                                q_pop_i
);

  localparam int DOC_W   = tkss_pkg::DOC_W;
  localparam int SCORE_W = tkss_pkg::SCORE_W;
  localparam int DEPTH   = tkss_pkg::QUEUE_DEPTH;
  localparam int PTR_W   = (tkss_pkg::QPTR_W > 0) ? tkss_pkg::QPTR_W : 1;
  localparam int CNT_W   = tkss_pkg::QCNT_W;

  tkss_pkg::tkss_cmd_t mem_q [DEPTH];
  tkss_pkg::tkss_cmd_t in_cmd;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                push, pop;

  // Classify the incoming word
  always_comb begin
    in_cmd.op    = s_axis_tuser ? tkss_pkg::OP_FINISH : tkss_pkg::OP_OFFER;
    in_cmd.doc   = s_axis_tdata[DOC_W-1:0];
    in_cmd.score = s_axis_tdata[DOC_W+SCORE_W-1:DOC_W];
  end

  assign s_axis_tready = (cnt_q != CNT_W'(DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_cmd_o       = mem_q[rd_ptr_q];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    case ({push, pop})
      2'b10:   cnt_d = CNT_W'(cnt_q + 1'b1);
      2'b01:   cnt_d = CNT_W'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tkss_back.sv =====
// Back part: slot store, scan sequencer for offers and finishes, output register.
`default_nettype none

module tkss_back #(
  parameter int MAX_SLOTS = tkss_pkg::MAX_SLOTS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [tkss_pkg::K_W-1:0]         cfg_wdata_i,
  input  wire                              q_valid_i,
  input  wire  tkss_pkg::tkss_cmd_t        q_cmd_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output tkss_pkg::tkss_result_t           out_o
);

  localparam int KCAP    = (MAX_SLOTS < tkss_pkg::RESULT_CAP) ? MAX_SLOTS
                                                              : tkss_pkg::RESULT_CAP;
  localparam int IDX_W   = (KCAP > 1) ? $clog2(KCAP) : 1;
  localparam int CNT_W   = $clog2(KCAP + 1);
  localparam int KRESET  = (tkss_pkg::K_RESET > KCAP) ? KCAP : tkss_pkg::K_RESET;
  localparam int DOC_W   = tkss_pkg::DOC_W;
  localparam int SCORE_W = tkss_pkg::SCORE_W;
  localparam int AGE_W   = tkss_pkg::AGE_W;
  localparam int RANK_W  = tkss_pkg::RANK_W;
  localparam int K_W     = tkss_pkg::K_W;

  // Slot store
  logic [SCORE_W-1:0] score_q [KCAP];
  logic [DOC_W-1:0]   doc_q   [KCAP];
  logic [AGE_W-1:0]   age_q   [KCAP];
  logic [KCAP-1:0]    valid_q;
  logic [KCAP-1:0]    emit_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   k_q;
  logic [CNT_W-1:0]   k_sat;

  // Sequencer state
  tkss_pkg::tkss_state_e state_q, state_d;
  logic [IDX_W-1:0]   scan_idx_q, scan_idx_d;
  logic [RANK_W-1:0]  rank_q, rank_d;
  logic [DOC_W-1:0]   cmd_doc_q, cmd_doc_d;
  logic [SCORE_W-1:0] cmd_score_q, cmd_score_d;

  // Scan trackers: selected slot (min for offers, best for finish)
  logic               has_sel_q, has_sel_d;
  logic [SCORE_W-1:0] sel_s_q, sel_s_d;
  logic [AGE_W-1:0]   sel_a_q, sel_a_d;
  logic [IDX_W-1:0]   sel_idx_q, sel_idx_d;
  logic [DOC_W-1:0]   sel_doc_q, sel_doc_d;
  logic               has_m2_q, has_m2_d;
  logic [SCORE_W-1:0] m2_q, m2_d;
  logic               has_empty_q, has_empty_d;
  logic [IDX_W-1:0]   empty_idx_q, empty_idx_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  tkss_pkg::tkss_result_t out_q, out_d;
  logic                   out_free;

  // Store update controls
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [AGE_W-1:0]   wr_age;
  logic               age_dec_en;
  logic [AGE_W-1:0]   age_gone;
  logic               mark_emit;
  logic               clear_store;
  logic               fill_new;

  // Scan read port
  logic               rd_valid;
  logic               rd_emit;
  logic [SCORE_W-1:0] rd_score;
  logic [DOC_W-1:0]   rd_doc;
  logic [AGE_W-1:0]   rd_age;
  logic [IDX_W-1:0]   k_last;
  logic               scan_end;
  logic               is_lower;
  logic               is_better;
  logic [SCORE_W-1:0] thr_tmp;
  tkss_pkg::tkss_result_t res;

  assign rd_valid = valid_q[scan_idx_q];
  assign rd_emit  = emit_q[scan_idx_q];
  assign rd_score = score_q[scan_idx_q];
  assign rd_doc   = doc_q[scan_idx_q];
  assign rd_age   = age_q[scan_idx_q];
  assign k_last   = IDX_W'(k_q - CNT_W'(1));
  assign scan_end = (scan_idx_q == k_last);
  assign out_free = !out_valid_q || out_ready_i;

  // Ordering tests against the selected slot
  assign is_lower  = !has_sel_q || (rd_score < sel_s_q) ||
                     ((rd_score == sel_s_q) && (rd_age < sel_a_q));
  assign is_better = !has_sel_q || (rd_score > sel_s_q) ||
                     ((rd_score == sel_s_q) && (rd_age < sel_a_q));

  // Saturate k into 1 .. KCAP
  always_comb begin
    if (cfg_wdata_i == '0) begin
      k_sat = CNT_W'(1);
    end else if (cfg_wdata_i > K_W'(KCAP)) begin
      k_sat = CNT_W'(KCAP);
    end else begin
      k_sat = CNT_W'(cfg_wdata_i);
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    scan_idx_d  = scan_idx_q;
    rank_d      = rank_q;
    cmd_doc_d   = cmd_doc_q;
    cmd_score_d = cmd_score_q;
    has_sel_d   = has_sel_q;
    sel_s_d     = sel_s_q;
    sel_a_d     = sel_a_q;
    sel_idx_d   = sel_idx_q;
    sel_doc_d   = sel_doc_q;
    has_m2_d    = has_m2_q;
    m2_d        = m2_q;
    has_empty_d = has_empty_q;
    empty_idx_d = empty_idx_q;
    count_d     = count_q;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = sel_idx_q;
    wr_age      = '0;
    age_dec_en  = 1'b0;
    age_gone    = sel_a_q;
    mark_emit   = 1'b0;
    clear_store = 1'b0;
    fill_new    = 1'b0;
    thr_tmp     = '0;
    res         = '0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      tkss_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o     = 1'b1;
          cmd_doc_d   = q_cmd_i.doc;
          cmd_score_d = q_cmd_i.score;
          scan_idx_d  = '0;
          rank_d      = '0;
          has_sel_d   = 1'b0;
          has_m2_d    = 1'b0;
          has_empty_d = 1'b0;
          if (q_cmd_i.op == tkss_pkg::OP_OFFER) begin
            state_d = tkss_pkg::ST_OFFER_SCAN;
          end else if (count_q == '0) begin
            state_d = tkss_pkg::ST_FIN_EMPTY;
          end else begin
            state_d = tkss_pkg::ST_FIN_SCAN;
          end
        end
      end

      // One slot a cycle: first empty slot, minimum, and runner-up score
      tkss_pkg::ST_OFFER_SCAN: begin
        if (!rd_valid) begin
          if (!has_empty_q) begin
            has_empty_d = 1'b1;
            empty_idx_d = scan_idx_q;
          end
        end else if (is_lower) begin
          if (has_sel_q) begin
            has_m2_d = 1'b1;
            m2_d     = (has_m2_q && (m2_q < sel_s_q)) ? m2_q : sel_s_q;
          end
          has_sel_d = 1'b1;
          sel_s_d   = rd_score;
          sel_a_d   = rd_age;
          sel_idx_d = scan_idx_q;
        end else begin
          has_m2_d = 1'b1;
          m2_d     = (has_m2_q && (m2_q < rd_score)) ? m2_q : rd_score;
        end
        if (scan_end) begin
          state_d = tkss_pkg::ST_OFFER_DONE;
        end else begin
          scan_idx_d = IDX_W'(scan_idx_q + 1'b1);
        end
      end

      // Update the store and post the offer result
      tkss_pkg::ST_OFFER_DONE: begin
        if (out_free) begin
          res.last = 1'b1;
          if (has_empty_q) begin
            fill_new = 1'b1;
            wr_en    = 1'b1;
            wr_idx   = empty_idx_q;
            wr_age   = AGE_W'(count_q);
            count_d  = CNT_W'(count_q + 1'b1);
            res.accepted        = 1'b1;
            res.threshold       = (has_sel_q && (sel_s_q < cmd_score_q)) ? sel_s_q
                                                                         : cmd_score_q;
            res.threshold_valid = (CNT_W'(count_q + 1'b1) == k_q);
          end else if (has_sel_q && (cmd_score_q > sel_s_q)) begin
            wr_en      = 1'b1;
            wr_idx     = sel_idx_q;
            wr_age     = AGE_W'(count_q - CNT_W'(1));
            age_dec_en = 1'b1;
            thr_tmp    = (has_m2_q && (m2_q < cmd_score_q)) ? m2_q : cmd_score_q;
            res.accepted        = 1'b1;
            res.threshold       = thr_tmp;
            res.threshold_valid = (count_q == k_q);
          end else begin
            res.threshold       = has_sel_q ? sel_s_q : '0;
            res.threshold_valid = (count_q == k_q);
          end
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = tkss_pkg::ST_IDLE;
        end
      end

      // One slot a cycle: best entry not yet sent
      tkss_pkg::ST_FIN_SCAN: begin
        if (rd_valid && !rd_emit && is_better) begin
          has_sel_d = 1'b1;
          sel_s_d   = rd_score;
          sel_a_d   = rd_age;
          sel_idx_d = scan_idx_q;
          sel_doc_d = rd_doc;
        end
        if (scan_end) begin
          state_d = tkss_pkg::ST_FIN_EMIT;
        end else begin
          scan_idx_d = IDX_W'(scan_idx_q + 1'b1);
        end
      end

      tkss_pkg::ST_FIN_EMIT: begin
        if (out_free) begin
          res.rank      = rank_q;
          res.out_doc   = sel_doc_q;
          res.out_score = sel_s_q;
          res.last      = (rank_q == RANK_W'(count_q - CNT_W'(1)));
          out_d         = res;
          out_valid_d   = 1'b1;
          mark_emit     = 1'b1;
          if (res.last) begin
            clear_store = 1'b1;
            count_d     = '0;
            state_d     = tkss_pkg::ST_IDLE;
          end else begin
            rank_d     = RANK_W'(rank_q + 1'b1);
            scan_idx_d = '0;
            has_sel_d  = 1'b0;
            state_d    = tkss_pkg::ST_FIN_SCAN;
          end
        end
      end

      tkss_pkg::ST_FIN_EMPTY: begin
        if (out_free) begin
          res.entry_empty = 1'b1;
          res.last        = 1'b1;
          out_d           = res;
          out_valid_d     = 1'b1;
          clear_store     = 1'b1;
          count_d         = '0;
          state_d         = tkss_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tkss_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkss_pkg::ST_IDLE;
      scan_idx_q  <= '0;
      rank_q      <= '0;
      has_sel_q   <= 1'b0;
      has_m2_q    <= 1'b0;
      has_empty_q <= 1'b0;
      count_q     <= '0;
      k_q         <= CNT_W'(KRESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      rank_q      <= rank_d;
      has_sel_q   <= has_sel_d;
      has_m2_q    <= has_m2_d;
      has_empty_q <= has_empty_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        k_q     <= k_sat;
        count_q <= '0;
      end else begin
        count_q <= count_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_doc_q   <= cmd_doc_d;
    cmd_score_q <= cmd_score_d;
    sel_s_q     <= sel_s_d;
    sel_a_q     <= sel_a_d;
    sel_idx_q   <= sel_idx_d;
    sel_doc_q   <= sel_doc_d;
    m2_q        <= m2_d;
    empty_idx_q <= empty_idx_d;
    out_q       <= out_d;
    if (wr_en) begin
      score_q[wr_idx] <= cmd_score_q;
      doc_q[wr_idx]   <= cmd_doc_q;
    end
  end

  // Valid, sent and age bits per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      emit_q  <= '0;
      for (int j = 0; j < KCAP; j++) begin
        age_q[j] <= '0;
      end
    end else if (clear_store || cfg_we_i) begin
      valid_q <= '0;
      emit_q  <= '0;
      for (int j = 0; j < KCAP; j++) begin
        age_q[j] <= '0;
      end
    end else begin
      for (int j = 0; j < KCAP; j++) begin
        if (wr_en && (wr_idx == IDX_W'(j))) begin
          age_q[j] <= wr_age;
        end else if (age_dec_en && valid_q[j] && (age_q[j] > age_gone)) begin
          age_q[j] <= AGE_W'(age_q[j] - 1'b1);
        end
        if (fill_new && (wr_idx == IDX_W'(j))) begin
          valid_q[j] <= 1'b1;
        end
        if (mark_emit && (sel_idx_q == IDX_W'(j))) begin
          emit_q[j] <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/top_k_score_selector.sv =====
// Top level of the top-k score selector: stream ports, front queue and back sequencer.
// An offer passes the back sequencer as command pop, a scan over k slots at one slot per
// cycle, then store update; its result word is registered at the store update, which waits
// for a free output register. A finish with n held entries runs one full slot scan per
// ranked word; an empty finish skips the scan. A two-word command queue keeps input open.
// Async active-low reset empties queue and store, sets k to 10; a k write empties the store.
`default_nettype none

module top_k_score_selector #(
  parameter int MAX_SLOTS = tkss_pkg::MAX_SLOTS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration: k_in_use
  input  wire                                 cfg_we_i,
  input  wire  [tkss_pkg::K_W-1:0]            cfg_wdata_i,
  // input stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [tkss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // doc_id, score
  input  wire                                 s_axis_tuser,  // kind
  // result stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // accepted, threshold, threshold_valid, rank, out_doc, out_score
  output logic [tkss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser,  // entry_empty
  output logic                                m_axis_tlast   // last
);

  localparam int PAY_W = 1 + tkss_pkg::SCORE_W + 1 + tkss_pkg::RANK_W
                         + tkss_pkg::DOC_W + tkss_pkg::SCORE_W;

  logic                   q_valid;
  logic                   q_pop;
  tkss_pkg::tkss_cmd_t    q_cmd;
  tkss_pkg::tkss_result_t res;

  tkss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd),
    .q_pop_i       (q_pop)
  );

  tkss_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Pack result word, first field in the low bits
  assign m_axis_tdata = {{(tkss_pkg::OUT_TDATA_W - PAY_W){1'b0}},
                         res.out_score, res.out_doc, res.rank,
                         res.threshold_valid, res.threshold, res.accepted};
  assign m_axis_tuser = res.entry_empty;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== tb/sv/top_k_score_selector_test.sv =====
// Self-checking testbench for the top-k score selector: directed table, then random traffic.
`timescale 1ns / 1ps

module top_k_score_selector_test;

  localparam int K_W         = tkss_pkg::K_W;
  localparam int DOC_W       = tkss_pkg::DOC_W;
  localparam int SCORE_W     = tkss_pkg::SCORE_W;
  localparam int AGE_W       = tkss_pkg::AGE_W;
  localparam int RANK_W      = tkss_pkg::RANK_W;
  localparam int IN_TDATA_W  = tkss_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = tkss_pkg::OUT_TDATA_W;
  localparam int RESULT_CAP  = tkss_pkg::RESULT_CAP;

  localparam int SLOTS       = tkss_pkg::MAX_SLOTS_DEF;
  localparam int SETTLE      = 2 * (SLOTS + 3);
  localparam int QUIET_LIMIT = 5000;
  localparam int SEG_ITEMS   = 40;

  // One directed step: a k write, or an input word with an optional typed-in answer
  typedef struct packed {
    logic                   is_cfg;
    logic [K_W-1:0]         cfg_val;
    tkss_pkg::tkss_op_e     kind;
    logic [DOC_W-1:0]       doc;
    logic [SCORE_W-1:0]     score;
    logic                   typed;
    tkss_pkg::tkss_result_t want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [K_W-1:0]         cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // doc_id, score
  logic                   s_axis_tuser;   // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // accepted, threshold, threshold_valid, rank,
                                          // out_doc, out_score
  logic                   m_axis_tuser;   // entry_empty
  logic                   m_axis_tlast;   // last

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  // Predictor state: the kept set and the k register
  logic [K_W-1:0]     k_setting;
  logic [SCORE_W-1:0] held_score [SLOTS];
  logic [DOC_W-1:0]   held_doc   [SLOTS];
  logic               held_valid [SLOTS];
  logic [AGE_W-1:0]   held_age   [SLOTS];

  tkss_pkg::tkss_result_t step_words [RESULT_CAP];
  tkss_pkg::tkss_result_t due_words  [$];
  dir_row_t               dir_rows   [$];

  top_k_score_selector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_held();
    for (int i = 0; i < SLOTS; i++) begin
      held_valid[i] = 1'b0;
      held_age[i]   = '0;
      held_score[i] = '0;
      held_doc[i]   = '0;
    end
  endfunction

  // Advance the kept set by one input word; fills step_words, returns the word count
  function automatic int select_step(input tkss_pkg::tkss_op_e kind,
                                     input logic [DOC_W-1:0] doc,
                                     input logic [SCORE_W-1:0] score);
    int k;
    int count;
    int empty_i;
    int min_i;
    int r;
    logic [AGE_W-1:0] gone;
    logic any;
    tkss_pkg::tkss_result_t w;
    k = (k_setting == 0) ? 1 : ((k_setting > SLOTS) ? SLOTS : int'(k_setting));
    count = 0;
    empty_i = -1;
    min_i = -1;
    w = '0;
    if (kind == tkss_pkg::OP_FINISH) begin
      for (int i = 0; i < k; i++) if (held_valid[i]) count++;
      if (count == 0) begin
        w.entry_empty = 1'b1;
        w.last = 1'b1;
        step_words[0] = w;
        clear_held();
        return 1;
      end
      // Rank: higher score first, older insert first on equal scores
      for (int i = 0; i < k; i++) begin
        if (!held_valid[i]) continue;
        r = 0;
        for (int j = 0; j < k; j++) begin
          if (j == i || !held_valid[j]) continue;
          if (held_score[j] > held_score[i] ||
              (held_score[j] == held_score[i] && held_age[j] < held_age[i])) r++;
        end
        w = '0;
        w.rank = r[RANK_W-1:0];
        w.out_doc = held_doc[i];
        w.out_score = held_score[i];
        w.last = (r == count - 1);
        step_words[r] = w;
      end
      clear_held();
      return count;
    end
    // Offer: find first empty slot and the oldest minimum
    for (int i = 0; i < k; i++) begin
      if (!held_valid[i]) begin
        if (empty_i < 0) empty_i = i;
      end else begin
        count++;
        if (min_i < 0 || held_score[i] < held_score[min_i] ||
            (held_score[i] == held_score[min_i] && held_age[i] < held_age[min_i])) min_i = i;
      end
    end
    if (empty_i >= 0) begin
      held_valid[empty_i] = 1'b1;
      held_score[empty_i] = score;
      held_doc[empty_i]   = doc;
      held_age[empty_i]   = count[AGE_W-1:0];
      count++;
      w.accepted = 1'b1;
    end else if (min_i >= 0 && score > held_score[min_i]) begin
      gone = held_age[min_i];
      for (int i = 0; i < k; i++)
        if (held_valid[i] && held_age[i] > gone) held_age[i]--;
      held_score[min_i] = score;
      held_doc[min_i]   = doc;
      held_age[min_i]   = AGE_W'(count - 1);
      w.accepted = 1'b1;
    end
    any = 1'b0;
    for (int i = 0; i < k; i++) begin
      if (held_valid[i] && (!any || held_score[i] < w.threshold)) begin
        w.threshold = held_score[i];
        any = 1'b1;
      end
    end
    w.threshold_valid = (count == k);
    w.last = 1'b1;
    step_words[0] = w;
    return 1;
  endfunction

  // Directed table helpers
  function automatic void add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic dir_row_t cfg_row(input logic [K_W-1:0] v);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  function automatic dir_row_t offer_row(input logic [DOC_W-1:0] doc,
                                         input logic [SCORE_W-1:0] score, input logic acc,
                                         input logic [SCORE_W-1:0] thr, input logic tv);
    dir_row_t row;
    row = '0;
    row.kind = tkss_pkg::OP_OFFER;
    row.doc = doc;
    row.score = score;
    row.typed = 1'b1;
    row.want.accepted = acc;
    row.want.threshold = thr;
    row.want.threshold_valid = tv;
    row.want.last = 1'b1;
    return row;
  endfunction

  // typed only for a finish on an empty store
  function automatic dir_row_t finish_row(input logic empty_store);
    dir_row_t row;
    row = '0;
    row.kind = tkss_pkg::OP_FINISH;
    row.typed = empty_store;
    row.want.entry_empty = 1'b1;
    row.want.last = 1'b1;
    return row;
  endfunction

  // Random content: ties, extremes and wide values
  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return SCORE_W'($urandom_range(15));
      4: return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DOC_W-1:0] pick_doc();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return DOC_W'($urandom());
    endcase
  endfunction

  // Send one word, then record what the selector should answer
  task automatic send_word(input tkss_pkg::tkss_op_e kind, input logic [DOC_W-1:0] doc,
                           input logic [SCORE_W-1:0] score, input logic typed,
                           input tkss_pkg::tkss_result_t want);
    int n;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, score, doc};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = select_step(kind, doc, score);
    if (typed) due_words.insert(due_words.size(), want);
    else for (int i = 0; i < n; i++) due_words.insert(due_words.size(), step_words[i]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
  endtask

  // k write: only with the selector idle; it also clears the kept set
  task automatic write_k(input logic [K_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_setting = v;
    clear_held();
  endtask

  // Result side: check each word, then pick the next ready level
  always @(posedge clk_i) begin : rx_side
    tkss_pkg::tkss_result_t got;
    tkss_pkg::tkss_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.accepted        = m_axis_tdata[0];
      got.threshold       = m_axis_tdata[32:1];
      got.threshold_valid = m_axis_tdata[33];
      got.rank            = m_axis_tdata[37:34];
      got.out_doc         = m_axis_tdata[68:38];
      got.out_score       = m_axis_tdata[100:69];
      got.entry_empty     = m_axis_tuser;
      got.last            = m_axis_tlast;
      if (due_words.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected word acc=%0b thr=%h tv=%0b rank=%0d doc=%h sc=%h e=%0b l=%0b",
                   $realtime, got.accepted, got.threshold, got.threshold_valid, got.rank,
                   got.out_doc, got.out_score, got.entry_empty, got.last);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("%0t: mismatch", $realtime);
            $display("  expected acc=%0b thr=%h tv=%0b rank=%0d doc=%h sc=%h e=%0b l=%0b",
                     want.accepted, want.threshold, want.threshold_valid, want.rank,
                     want.out_doc, want.out_score, want.entry_empty, want.last);
            $display("  actual   acc=%0b thr=%h tv=%0b rank=%0d doc=%h sc=%h e=%0b l=%0b",
                     got.accepted, got.threshold, got.threshold_valid, got.rank,
                     got.out_doc, got.out_score, got.entry_empty, got.last);
          end
          mismatches++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("top_k_score_selector_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [K_W-1:0] seg_k [8];
    tkss_pkg::tkss_op_e kind;
    int k_eff;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    k_setting     = K_W'(tkss_pkg::K_RESET);
    clear_held();
    seg_k = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd17, 5'd10, 5'd7};

    // Directed table; k starts at its reset value
    add_row(finish_row(1'b1));                                         // empty after reset
    add_row(offer_row(31'h0, 32'h0, 1'b1, 32'h0, 1'b0));
    add_row(offer_row(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0));
    add_row(offer_row(31'h2AAA_AAAA, 32'hAAAA_AAAA, 1'b1, 32'h0, 1'b0));
    add_row(offer_row(31'h5555_5555, 32'h5555_5555, 1'b1, 32'h0, 1'b0));
    add_row(finish_row(1'b0));
    add_row(cfg_row(5'd0));                                            // zero acts as one
    add_row(offer_row(31'd5, 32'd100, 1'b1, 32'd100, 1'b1));
    add_row(offer_row(31'd6, 32'd100, 1'b0, 32'd100, 1'b1));            // equal, not kept
    add_row(offer_row(31'd7, 32'd101, 1'b1, 32'd101, 1'b1));
    add_row(offer_row(31'd8, 32'd0, 1'b0, 32'd101, 1'b1));
    add_row(finish_row(1'b0));
    add_row(cfg_row(5'd2));
    add_row(offer_row(31'd1, 32'd50, 1'b1, 32'd50, 1'b0));
    add_row(offer_row(31'd2, 32'd50, 1'b1, 32'd50, 1'b1));
    add_row(offer_row(31'd3, 32'd60, 1'b1, 32'd50, 1'b1));              // evicts older tie
    add_row(offer_row(31'd4, 32'd50, 1'b0, 32'd50, 1'b1));
    add_row(finish_row(1'b0));
    add_row(offer_row(31'd10, 32'd70, 1'b1, 32'd70, 1'b0));
    add_row(offer_row(31'd11, 32'd70, 1'b1, 32'd70, 1'b1));
    add_row(offer_row(31'd12, 32'd40, 1'b0, 32'd70, 1'b1));
    add_row(finish_row(1'b0));                                         // tie order on drain
    add_row(offer_row(31'd9, 32'd1, 1'b1, 32'd1, 1'b0));
    add_row(cfg_row(5'd31));                                           // write clears, k caps
    add_row(finish_row(1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_k(dir_rows[i].cfg_val);
      else send_word(dir_rows[i].kind, dir_rows[i].doc, dir_rows[i].score,
                     dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: four idling phases, two k settings each
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      write_k(seg_k[seg]);
      k_eff = (seg_k[seg] == 0) ? 1 : ((seg_k[seg] > SLOTS) ? SLOTS : int'(seg_k[seg]));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // hold off until the selector has answered everything
        if (n == SEG_ITEMS / 2 || $urandom_range(39) == 0) wait_drained();
        kind = ($urandom_range(k_eff + 4) == 0) ? tkss_pkg::OP_FINISH : tkss_pkg::OP_OFFER;
        send_word(kind, pick_doc(), pick_score(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("top_k_score_selector_test passed");
    end else begin
      $display("top_k_score_selector_test failed");
    end
    $finish;
  end

endmodule
